// ===== hw/rtl/numeric_stream_statistics_top_defines.svh =====
// Assertion macros for the numeric stream statistics RTL, used by the result emitter.
`ifndef NUMERIC_STREAM_STATISTICS_TOP_DEFINES_SVH
`define NUMERIC_STREAM_STATISTICS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define NSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define NSS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NSS_ASSERT(lbl, clk, rst, prop, msg)
`define NSS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/nss_pkg.sv =====
// Shared types, constants and helper functions for the numeric stream statistics block.
package nss_pkg;

   localparam int          NUM_STATS = 18;
   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [6:0]  NO_TZ     = 7'd64;

   localparam logic [1:0] WIDTH_1B = 2'd0;
   localparam logic [1:0] WIDTH_2B = 2'd1;
   localparam logic [1:0] WIDTH_4B = 2'd2;
   localparam logic [1:0] WIDTH_8B = 2'd3;

   localparam logic [4:0] STAT_COUNT    = 5'd0;
   localparam logic [4:0] STAT_UMIN     = 5'd1;
   localparam logic [4:0] STAT_UMAX     = 5'd2;
   localparam logic [4:0] STAT_USUM     = 5'd3;
   localparam logic [4:0] STAT_SMIN     = 5'd4;
   localparam logic [4:0] STAT_SMAX     = 5'd5;
   localparam logic [4:0] STAT_SSUM     = 5'd6;
   localparam logic [4:0] STAT_MAXRUN   = 5'd7;
   localparam logic [4:0] STAT_MAXUDLT  = 5'd8;
   localparam logic [4:0] STAT_MAXSDLT  = 5'd9;
   localparam logic [4:0] STAT_ZEROS    = 5'd10;
   localparam logic [4:0] STAT_UPS      = 5'd11;
   localparam logic [4:0] STAT_DOWNS    = 5'd12;
   localparam logic [4:0] STAT_DMIN     = 5'd13;
   localparam logic [4:0] STAT_DMAX     = 5'd14;
   localparam logic [4:0] STAT_MINTZ    = 5'd15;
   localparam logic [4:0] STAT_URANGE   = 5'd16;
   localparam logic [4:0] STAT_SRANGE   = 5'd17;

   // Frozen end-of-block totals handed from the accumulator to the emitter.
   typedef struct packed {
      logic [31:0] count;
      logic [63:0] umin;
      logic [63:0] umax;
      logic [63:0] usum;
      logic [63:0] smin;
      logic [63:0] smax;
      logic [63:0] sum_lo;
      logic [63:0] sum_hi;
      logic [1:0]  sum_adj;   // pending -1/0/+1 still owed to sum_hi
      logic [31:0] run_best;
      logic [63:0] udelta;
      logic [63:0] sdelta;
      logic [31:0] zeros;
      logic [31:0] ups;
      logic [31:0] downs;
      logic [63:0] dmin;
      logic [63:0] dmax;
      logic [6:0]  mintz;
   } nss_snap_type;

   function automatic logic [63:0] lane_mask(input logic [1:0] code);
      logic [63:0] m;
      case (code)
         WIDTH_1B: m = 64'h0000_0000_0000_00FF;
         WIDTH_2B: m = 64'h0000_0000_0000_FFFF;
         WIDTH_4B: m = 64'h0000_0000_FFFF_FFFF;
         default:  m = '1;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] code);
      logic [63:0] m;
      logic [63:0] t;
      logic        sgn;
      m = lane_mask(code);
      t = v & m;
      case (code)
         WIDTH_1B: sgn = t[7];
         WIDTH_2B: sgn = t[15];
         WIDTH_4B: sgn = t[31];
         default:  sgn = 1'b0;
      endcase
      return sgn ? (t | ~m) : t;
   endfunction

   function automatic logic s_less(input logic [63:0] a, input logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] x);
      return (x == '1) ? x : x + 32'd1;
   endfunction

   // Index of the lowest set bit; 64 when the word is zero.
   function automatic logic [6:0] tz64(input logic [63:0] v);
      logic [6:0] n;
      n = NO_TZ;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) n = 7'(i);
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/numeric_stream_statistics_top.sv =====
// Top level of the numeric stream statistics block: ports, input register, width register.
// Each request carries one element; the block accepts one request per cycle while req_stall
// is low and keeps min/max/sum, run, delta, transition, zero and trailing-zero statistics for
// the current block. A request with req_end_of_block set closes the block: its totals are
// frozen into a snapshot and 18 results (stat ids 0 through 17, rsp_last_stat on id 17) leave
// on the rsp channel, one per cycle unless rsp_stall holds them, while the next block's
// requests keep streaming in. Only one snapshot exists, so a second end-of-block request is
// held in the input register until the cycle after the previous block's 18th result has been
// loaded into the output register; sustained rate is one request per cycle, lower when blocks
// are too short to cover the previous snapshot's drain. From the input register an accepted
// end-of-block request passes through the snapshot and output registers to its first result.
// The element width register is written through the csr port, which is always ready; it
// should only be changed while the block is idle and takes effect on the next element.
module numeric_stream_statistics_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic        req_end_of_block,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_stat_id,
   output logic [63:0] rsp_stat_value,
   output logic        rsp_last_stat,
   // width register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_width_code
);
   import nss_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [63:0]  in_value_ff, in_value_in;
   logic         in_eob_ff, in_eob_in;
   logic [1:0]   width_code_ff, width_code_in;
   logic         item_consume, snap_load, snap_busy;
   logic         req_take;
   nss_snap_type snap;

   assign csr_ready = 1'b1;

   // The input register frees when its request is consumed by the accumulator.
   assign req_stall = in_valid_ff && !item_consume;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in   = req_take || (in_valid_ff && !item_consume);
      in_value_in   = req_take ? req_value : in_value_ff;
      in_eob_in     = req_take ? req_end_of_block : in_eob_ff;
      width_code_in = (csr_valid && csr_ready) ? csr_width_code : width_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         width_code_ff <= WIDTH_8B;
      end else begin
         in_valid_ff   <= in_valid_in;
         width_code_ff <= width_code_in;
      end
   end

   always_ff @(posedge clock) begin
      in_value_ff <= in_value_in;
      in_eob_ff   <= in_eob_in;
   end

   nss_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (in_valid_ff),
      .item_value   (in_value_ff),
      .item_eob     (in_eob_ff),
      .width_code   (width_code_ff),
      .snap_busy    (snap_busy),
      .item_consume (item_consume),
      .snap_load    (snap_load),
      .snap         (snap)
   );

   nss_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .snap_load      (snap_load),
      .snap           (snap),
      .snap_busy      (snap_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_stat_id    (rsp_stat_id),
      .rsp_stat_value (rsp_stat_value),
      .rsp_last_stat  (rsp_last_stat)
   );

endmodule

// ===== hw/rtl/nss_accum.sv =====
// Per-element accumulator: updates block statistics and freezes them on end of block.
module nss_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [63:0]           item_value,
   input  logic                  item_eob,
   input  logic [1:0]            width_code,
   input  logic                  snap_busy,
   output logic                  item_consume,
   output logic                  snap_load,
   output nss_pkg::nss_snap_type snap
);
   import nss_pkg::*;

   typedef struct packed {
      logic        started;
      logic [31:0] total;
      logic [63:0] prev;
      logic [63:0] umin;
      logic [63:0] umax;
      logic [63:0] usum;
      logic [63:0] smin;
      logic [63:0] smax;
      logic [63:0] sum_lo;
      logic [63:0] sum_hi;
      logic [1:0]  sum_adj;
      logic [31:0] run_now;
      logic [31:0] run_best;
      logic [63:0] udelta;
      logic [63:0] sdelta;
      logic [63:0] dmin;
      logic [63:0] dmax;
      logic [31:0] zeros;
      logic [31:0] ups;
      logic [31:0] downs;
      logic [6:0]  tz;
      logic        nonzero;
   } acc_type;

   acc_type     state_ff, state_in, nx, clr;
   logic [63:0] u, s, ps, diff_sp, diff_ps, umag, smag, sd, lo_add;
   logic        s_ge, carry;
   logic [6:0]  tz_now;
   logic        fire;

   // An end-of-block element waits until the emitter's snapshot is free.
   assign item_consume = !item_eob || !snap_busy;
   assign fire         = item_valid && item_consume;
   assign snap_load    = fire && item_eob;

   always_comb begin
      u       = item_value & lane_mask(width_code);
      s       = sign_ext(u, width_code);
      ps      = sign_ext(state_ff.prev, width_code);
      diff_sp = s - ps;
      diff_ps = ps - s;
      s_ge    = !s_less(s, ps);
      smag    = s_ge ? diff_sp : diff_ps;
      if (s_ge) begin
         sd = (diff_sp > S64_MAX) ? S64_MAX : diff_sp;
      end else begin
         sd = (diff_ps > SIGN_BIT) ? SIGN_BIT : diff_sp;
      end
      umag   = (u > state_ff.prev) ? (u - state_ff.prev) : (state_ff.prev - u);
      lo_add = state_ff.sum_lo + s;
      carry  = lo_add < s;
      tz_now = tz64(u);

      nx = state_ff;
      if (!state_ff.started) begin
         nx.started  = 1'b1;
         nx.total    = 32'd1;
         nx.umin     = u;
         nx.umax     = u;
         nx.usum     = u;
         nx.smin     = s;
         nx.smax     = s;
         nx.sum_lo   = s;
         nx.sum_hi   = '0;
         nx.sum_adj  = s[63] ? 2'b11 : 2'b00;
         nx.run_now  = 32'd1;
         nx.run_best = 32'd1;
      end else begin
         nx.total   = sat_inc32(state_ff.total);
         nx.umin    = (u < state_ff.umin) ? u : state_ff.umin;
         nx.umax    = (u > state_ff.umax) ? u : state_ff.umax;
         nx.smin    = s_less(s, state_ff.smin) ? s : state_ff.smin;
         nx.smax    = s_less(state_ff.smax, s) ? s : state_ff.smax;
         nx.usum    = state_ff.usum + u;
         nx.sum_lo  = lo_add;
         // the high word lags by one element: apply the owed step, record the new one
         nx.sum_hi  = state_ff.sum_hi + {{62{state_ff.sum_adj[1]}}, state_ff.sum_adj};
         nx.sum_adj = {1'b0, carry} - {1'b0, s[63]};
         nx.udelta  = (umag > state_ff.udelta) ? umag : state_ff.udelta;
         nx.sdelta  = (smag > state_ff.sdelta) ? smag : state_ff.sdelta;
         nx.dmin    = s_less(sd, state_ff.dmin) ? sd : state_ff.dmin;
         nx.dmax    = s_less(state_ff.dmax, sd) ? sd : state_ff.dmax;
         if (u == state_ff.prev) begin
            nx.run_now  = sat_inc32(state_ff.run_now);
            nx.run_best = (nx.run_now > state_ff.run_best) ? nx.run_now : state_ff.run_best;
         end else begin
            if (u > state_ff.prev) begin
               nx.ups = sat_inc32(state_ff.ups);
            end else begin
               nx.downs = sat_inc32(state_ff.downs);
            end
            nx.run_now = 32'd1;
         end
      end
      if (u == '0) begin
         nx.zeros = sat_inc32(state_ff.zeros);
      end else begin
         nx.nonzero = 1'b1;
         nx.tz      = (tz_now < state_ff.tz) ? tz_now : state_ff.tz;
      end
      nx.prev = u;

      clr    = '0;
      clr.tz = NO_TZ;

      if (fire) begin
         state_in = item_eob ? clr : nx;
      end else begin
         state_in = state_ff;
      end

      snap.count    = nx.total;
      snap.umin     = nx.umin;
      snap.umax     = nx.umax;
      snap.usum     = nx.usum;
      snap.smin     = nx.smin;
      snap.smax     = nx.smax;
      snap.sum_lo   = nx.sum_lo;
      snap.sum_hi   = nx.sum_hi;
      snap.sum_adj  = nx.sum_adj;
      snap.run_best = nx.run_best;
      snap.udelta   = nx.udelta;
      snap.sdelta   = nx.sdelta;
      snap.zeros    = nx.zeros;
      snap.ups      = nx.ups;
      snap.downs    = nx.downs;
      snap.dmin     = nx.dmin;
      snap.dmax     = nx.dmax;
      snap.mintz    = nx.nonzero ? nx.tz : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clr;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/nss_emit.sv =====
// Result emitter: holds one block snapshot and streams its statistics one per cycle unless rsp_stall holds them.
`include "numeric_stream_statistics_top_defines.svh"
module nss_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_load,
   input  nss_pkg::nss_snap_type snap,
   output logic                  snap_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [4:0]            rsp_stat_id,
   output logic [63:0]           rsp_stat_value,
   output logic                  rsp_last_stat
);
   import nss_pkg::*;

   nss_snap_type snap_ff, snap_in;
   logic         busy_ff, busy_in;
   logic [4:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [4:0]   rsp_id_ff, rsp_id_in;
   logic [63:0]  rsp_value_ff, rsp_value_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         load_out, at_last;
   logic [63:0]  stat_sel, hi_final, ext;

   assign snap_busy      = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stat_id    = rsp_id_ff;
   assign rsp_stat_value = rsp_value_ff;
   assign rsp_last_stat  = rsp_last_ff;

   assign load_out = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last  = idx_ff == STAT_SRANGE;

   always_comb begin
      hi_final = snap_ff.sum_hi + {{62{snap_ff.sum_adj[1]}}, snap_ff.sum_adj};
      ext      = {64{snap_ff.sum_lo[63]}};
      case (idx_ff)
         STAT_COUNT:   stat_sel = {32'd0, snap_ff.count};
         STAT_UMIN:    stat_sel = snap_ff.umin;
         STAT_UMAX:    stat_sel = snap_ff.umax;
         STAT_USUM:    stat_sel = snap_ff.usum;
         STAT_SMIN:    stat_sel = snap_ff.smin;
         STAT_SMAX:    stat_sel = snap_ff.smax;
         STAT_SSUM: begin
            if (hi_final == ext) stat_sel = snap_ff.sum_lo;
            else                 stat_sel = hi_final[63] ? SIGN_BIT : S64_MAX;
         end
         STAT_MAXRUN:  stat_sel = {32'd0, snap_ff.run_best};
         STAT_MAXUDLT: stat_sel = snap_ff.udelta;
         STAT_MAXSDLT: stat_sel = snap_ff.sdelta;
         STAT_ZEROS:   stat_sel = {32'd0, snap_ff.zeros};
         STAT_UPS:     stat_sel = {32'd0, snap_ff.ups};
         STAT_DOWNS:   stat_sel = {32'd0, snap_ff.downs};
         STAT_DMIN:    stat_sel = snap_ff.dmin;
         STAT_DMAX:    stat_sel = snap_ff.dmax;
         STAT_MINTZ:   stat_sel = {57'd0, snap_ff.mintz};
         STAT_URANGE:  stat_sel = snap_ff.umax - snap_ff.umin;
         STAT_SRANGE:  stat_sel = snap_ff.smax - snap_ff.smin;
         default:      stat_sel = '0;
      endcase

      snap_in      = snap_load ? snap : snap_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = idx_ff;
         rsp_value_in = stat_sel;
         rsp_last_in  = at_last;
         idx_in       = at_last ? 5'd0 : idx_ff + 5'd1;
         busy_in      = !at_last;
      end
      if (snap_load) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff      <= snap_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `NSS_NEVER(a_idx_range, clock, reset, idx_ff > STAT_SRANGE, "stat index out of range")
   `NSS_NEVER(a_snap_overrun, clock, reset, snap_load && busy_ff, "snapshot overwritten while busy")
   `NSS_ASSERT(a_last_matches_id, clock, reset, rsp_valid_ff |-> (rsp_last_ff == (rsp_id_ff == STAT_SRANGE)), "last flag disagrees with stat id")
   `NSS_ASSERT(a_done_frees, clock, reset, (load_out && at_last && !snap_load) |=> (!busy_ff && idx_ff == 5'd0), "emitter not idle after last stat")

endmodule
